// ----- src/bpa_pkg.sv -----
// ----------------------------------------------------------------------------
// Bit-packed array store package
// Shared constants, command and status codes, and the classified-op type
// passed from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package bpa_pkg;

    // Store geometry
    localparam int STORE_WORDS = 512;
    localparam int WORD_W      = 64;
    localparam int ADDR_W      = $clog2(STORE_WORDS);
    localparam int SH_W        = 6;

    // Field widths
    localparam int CMD_W       = 1;
    localparam int IDX_W       = 15;
    localparam int VAL_W       = 57;
    localparam int CFG_W       = 6;

    // Element width limits
    localparam logic [CFG_W-1:0] WIDTH_MIN   = 6'd1;
    localparam logic [CFG_W-1:0] WIDTH_MAX   = 6'd57;
    localparam logic [CFG_W-1:0] WIDTH_RESET = 6'd8;

    // Bit offset arithmetic: wide enough for the largest store and index
    localparam int OFF_W       = 23;
    localparam logic [OFF_W-1:0] CAP_BITS = OFF_W'(STORE_WORDS * WORD_W);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_READ  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 1'b1;

    // Status codes
    localparam logic STATUS_DONE  = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    // Queue depth between front and back
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    // Classified operation
    typedef struct packed {
        logic              is_write;
        logic              is_err;
        logic              straddle;
        logic [ADDR_W-1:0] word;
        logic [SH_W-1:0]   sh;
        logic [VAL_W-1:0]  mask;
        logic [VAL_W-1:0]  value;
    } op_t;

endpackage

// ----- src/bpa_ifs.sv -----
// ----------------------------------------------------------------------------
// Bit-packed array store channel interfaces
// Request channel (command, index, value) and response channel
// (read value, status), both valid/ready.
// ----------------------------------------------------------------------------
interface bpa_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [bpa_pkg::CMD_W-1:0]    command;
    logic [bpa_pkg::IDX_W-1:0]    element_index;
    logic [bpa_pkg::VAL_W-1:0]    write_value;

    modport source (output valid, command, element_index, write_value, input ready);
    modport sink   (input valid, command, element_index, write_value, output ready);
endinterface

interface bpa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [bpa_pkg::VAL_W-1:0]    read_value;
    logic                         status;

    modport source (output valid, read_value, status, input ready);
    modport sink   (input valid, read_value, status, output ready);
endinterface

// ----- src/bpa_front.sv -----
// ----------------------------------------------------------------------------
// Bit-packed array store front end
// Holds the element width register, accepts request items and classifies
// them: bit offset, word address, shift, straddle, range check, masks.
// ----------------------------------------------------------------------------
module bpa_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bpa_pkg::CFG_W-1:0]     cfg_wdata,
    bpa_cmd_if.sink                       req,
    input  logic                          q_full,
    input  logic                          clearing,
    output logic                          push,
    output bpa_pkg::op_t                  op
);

    logic [bpa_pkg::CFG_W-1:0] width_reg;
    logic [bpa_pkg::CFG_W-1:0] width_eff;
    logic [bpa_pkg::OFF_W-1:0] offset;
    logic [bpa_pkg::OFF_W-1:0] end_bit;
    logic [bpa_pkg::VAL_W-1:0] mask;

    // Element width register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= bpa_pkg::WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            width_reg <= cfg_wdata;
        end
    end

    // Clamp to the usable range
    always_comb
    begin
        if (width_reg < bpa_pkg::WIDTH_MIN)
        begin
            width_eff = bpa_pkg::WIDTH_MIN;
        end
        else if (width_reg > bpa_pkg::WIDTH_MAX)
        begin
            width_eff = bpa_pkg::WIDTH_MAX;
        end
        else
        begin
            width_eff = width_reg;
        end
    end

    // Slot position and range check
    assign offset  = bpa_pkg::OFF_W'(req.element_index) * bpa_pkg::OFF_W'(width_eff);
    assign end_bit = offset + bpa_pkg::OFF_W'(width_eff);
    // width of 57 wraps to zero before the decrement, giving all ones
    assign mask    = (bpa_pkg::VAL_W'(1) << width_eff) - bpa_pkg::VAL_W'(1);

    // Classified item
    always_comb
    begin
        op.is_write = (req.command == bpa_pkg::CMD_WRITE);
        op.is_err   = (end_bit > bpa_pkg::CAP_BITS);
        op.word     = offset[bpa_pkg::ADDR_W+bpa_pkg::SH_W-1:bpa_pkg::SH_W];
        op.sh       = offset[bpa_pkg::SH_W-1:0];
        op.straddle = ({1'b0, offset[bpa_pkg::SH_W-1:0]} + {1'b0, width_eff})
                      > 7'(bpa_pkg::WORD_W);
        op.mask     = mask;
        op.value    = req.write_value & mask;
    end

    // Handshake
    assign req.ready = !q_full && !clearing;
    assign push      = req.valid && req.ready;

endmodule

// ----- src/bpa_queue.sv -----
// ----------------------------------------------------------------------------
// Bit-packed array store op queue
// Small FIFO of classified items between front and back end.
// ----------------------------------------------------------------------------
module bpa_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bpa_pkg::op_t  push_op,
    input  logic          pop,
    output logic          full,
    output logic          head_valid,
    output bpa_pkg::op_t  head_op
);

    bpa_pkg::op_t                  entry_reg [bpa_pkg::Q_DEPTH];
    logic [bpa_pkg::Q_PTR_W-1:0]   wr_ptr_reg;
    logic [bpa_pkg::Q_PTR_W-1:0]   rd_ptr_reg;
    logic [bpa_pkg::Q_CNT_W-1:0]   count_reg;

    assign full       = (count_reg == bpa_pkg::Q_CNT_W'(bpa_pkg::Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = entry_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == bpa_pkg::Q_PTR_W'(bpa_pkg::Q_DEPTH - 1))
                              ? '0 : wr_ptr_reg + bpa_pkg::Q_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == bpa_pkg::Q_PTR_W'(bpa_pkg::Q_DEPTH - 1))
                              ? '0 : rd_ptr_reg + bpa_pkg::Q_PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + bpa_pkg::Q_CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - bpa_pkg::Q_CNT_W'(1);
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ----- src/bpa_back.sv -----
// ----------------------------------------------------------------------------
// Bit-packed array store back end
// Owns the packed word memory. Clears it after reset, then runs each
// queued item as a read or read-modify-write of one or two words (a range
// error reads nothing) and places the result item in the output register.
// ----------------------------------------------------------------------------
module bpa_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  bpa_pkg::op_t  head_op,
    output logic          pop,
    output logic          clearing,
    bpa_rsp_if.source     rsp
);

    localparam int PAIR_W = 2 * bpa_pkg::WORD_W;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_RD1   = 5'b00100,
        S_RD2   = 5'b01000,
        S_WR2   = 5'b10000
    } state_t;

    logic [bpa_pkg::WORD_W-1:0]  mem [bpa_pkg::STORE_WORDS];

    state_t                      state_reg, state_next;
    logic [bpa_pkg::ADDR_W-1:0]  clr_cnt_reg, clr_cnt_next;
    bpa_pkg::op_t                op_reg, op_next;
    logic [PAIR_W-1:0]           smask_reg, smask_next;
    logic [PAIR_W-1:0]           sval_reg, sval_next;
    logic [bpa_pkg::WORD_W-1:0]  lo_reg, lo_next;
    logic [bpa_pkg::WORD_W-1:0]  hi_new_reg, hi_new_next;
    logic                        out_valid_reg, out_valid_next;
    logic [bpa_pkg::VAL_W-1:0]   out_value_reg, out_value_next;
    logic                        out_status_reg, out_status_next;

    logic [bpa_pkg::WORD_W-1:0]  rd_data_reg;
    logic                        rd_en;
    logic [bpa_pkg::ADDR_W-1:0]  rd_addr;
    logic                        wr_en;
    logic [bpa_pkg::ADDR_W-1:0]  wr_addr;
    logic [bpa_pkg::WORD_W-1:0]  wr_data;
    logic [PAIR_W-1:0]           pair;
    logic [PAIR_W-1:0]           pair_new;
    logic                        slot_free;

    // Word memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Output register frees when taken
    assign slot_free  = !out_valid_reg || rsp.ready;
    assign rsp.valid  = out_valid_reg;
    assign rsp.read_value = out_value_reg;
    assign rsp.status = out_status_reg;
    assign clearing   = (state_reg == S_CLEAR);

    // Word pair view: high word is only meaningful in S_RD2
    assign pair     = (state_reg == S_RD2) ? {rd_data_reg, lo_reg}
                                           : {{bpa_pkg::WORD_W{1'b0}}, rd_data_reg};
    assign pair_new = (pair & ~smask_reg) | sval_reg;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        op_next         = op_reg;
        smask_next      = smask_reg;
        sval_next       = sval_reg;
        lo_next         = lo_reg;
        hi_new_next     = hi_new_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        pop             = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = op_reg.word;
        wr_en           = 1'b0;
        wr_addr         = op_reg.word;
        wr_data         = pair_new[bpa_pkg::WORD_W-1:0];

        case (state_reg)
            S_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_data      = '0;
                clr_cnt_next = clr_cnt_reg + bpa_pkg::ADDR_W'(1);
                if (clr_cnt_reg == bpa_pkg::ADDR_W'(bpa_pkg::STORE_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (head_valid && slot_free)
                begin
                    pop        = 1'b1;
                    op_next    = head_op;
                    smask_next = PAIR_W'(head_op.mask) << head_op.sh;
                    sval_next  = PAIR_W'(head_op.value) << head_op.sh;
                    if (head_op.is_err)
                    begin
                        out_valid_next  = 1'b1;
                        out_value_next  = '0;
                        out_status_next = bpa_pkg::STATUS_RANGE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = head_op.word;
                        state_next = S_RD1;
                    end
                end
            end

            S_RD1:
            begin
                // low word has arrived; fetch the next one in case of straddle
                lo_next = rd_data_reg;
                rd_en   = 1'b1;
                rd_addr = op_reg.word + bpa_pkg::ADDR_W'(1);
                if (op_reg.straddle)
                begin
                    state_next = S_RD2;
                end
                else
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = bpa_pkg::STATUS_DONE;
                    if (op_reg.is_write)
                    begin
                        wr_en          = 1'b1;
                        out_value_next = '0;
                    end
                    else
                    begin
                        out_value_next = bpa_pkg::VAL_W'(pair >> op_reg.sh) & op_reg.mask;
                    end
                    state_next = S_IDLE;
                end
            end

            S_RD2:
            begin
                if (op_reg.is_write)
                begin
                    wr_en       = 1'b1;
                    hi_new_next = pair_new[PAIR_W-1:bpa_pkg::WORD_W];
                    state_next  = S_WR2;
                end
                else
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = bpa_pkg::STATUS_DONE;
                    out_value_next  = bpa_pkg::VAL_W'(pair >> op_reg.sh) & op_reg.mask;
                    state_next      = S_IDLE;
                end
            end

            S_WR2:
            begin
                wr_en           = 1'b1;
                wr_addr         = op_reg.word + bpa_pkg::ADDR_W'(1);
                wr_data         = hi_new_reg;
                out_valid_next  = 1'b1;
                out_value_next  = '0;
                out_status_next = bpa_pkg::STATUS_DONE;
                state_next      = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        smask_reg      <= smask_next;
        sval_reg       <= sval_next;
        lo_reg         <= lo_next;
        hi_new_reg     <= hi_new_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

endmodule

// ----- src/bit_packed_array_store_top.sv -----
// A range error goes straight to the output register; an in-word item reads
// its word, then answers or writes it back; a straddling item also reads the
// next word, and a straddling write writes back both. The back end runs one
// item at a time on its single word memory ports; the queue takes more while
// not full. Reset: asynchronous, active low; a clearing pass then zeroes the
// memory, one word a cycle, with no item accepted until it completes.
// ----------------------------------------------------------------------------
// Bit-packed array store top level
// Packed array of configurable-width elements: front end classifier,
// op queue and memory back end.
// ----------------------------------------------------------------------------
module bit_packed_array_store_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bpa_pkg::CFG_W-1:0]     cfg_wdata,
    bpa_cmd_if.sink                       req,
    bpa_rsp_if.source                     rsp
);

    logic          push;
    logic          pop;
    logic          q_full;
    logic          head_valid;
    logic          clearing;
    bpa_pkg::op_t  push_op;
    bpa_pkg::op_t  head_op;

    // Classifier
    bpa_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .q_full    (q_full),
        .clearing  (clearing),
        .push      (push),
        .op        (push_op)
    );

    // Op queue
    bpa_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    // Memory back end
    bpa_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_op    (head_op),
        .pop        (pop),
        .clearing   (clearing),
        .rsp        (rsp)
    );

endmodule
